// ===== rtl/mnc_pkg.sv =====
// ----------------------------------------------------------------------------
// mnc_pkg: shared types and constants of the 3x3 mine neighbour counter
// Item layouts, the line-store cell contents and the register indexes.
// ----------------------------------------------------------------------------
package mnc_pkg;

   // configuration register fields
   localparam int GRID_WIDTH_W   = 7;
   localparam int GRID_HEIGHT_W  = 11;
   localparam int CSR_DATA_W     = 11;
   localparam int GRID_WIDTH_RST  = 8;
   localparam int GRID_HEIGHT_RST = 8;
   localparam int GRID_WIDTH_TOP  = 127;
   localparam int GRID_HEIGHT_TOP = 2047;

   // register indexes
   localparam logic CSR_GRID_WIDTH  = 1'b0;
   localparam logic CSR_GRID_HEIGHT = 1'b1;

   // item opcodes
   localparam logic OP_CELL  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam int COUNT_W   = 4;
   localparam int COUNT_MAX = 9;

   typedef struct packed {
      logic opcode;
      logic is_mine;
   } req_item_type;

   typedef struct packed {
      logic [COUNT_W-1:0] mine_count;
      logic               row_end;
      logic               frame_end;
   } rsp_item_type;

   // one column of the two line stores
   typedef struct packed {
      logic upper;
      logic middle;
   } line_bits_type;

endpackage

// ===== rtl/mnc_cell.sv =====
// ----------------------------------------------------------------------------
// mnc_cell: one column slot of the line-store chain
// Holds the upper and middle row bits of one column and moves them one
// slot towards the read end on every item; the slot at the row's last
// column takes the freshly written column instead.
// ----------------------------------------------------------------------------
module mnc_cell
   import mnc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          clear,
   input  logic          shift,
   input  logic          load,
   input  line_bits_type ins,
   input  line_bits_type from_right,
   output line_bits_type bits_q
);

   line_bits_type bits_ff;
   line_bits_type bits_in;

   always_comb begin
      bits_in = bits_ff;
      if (shift) begin
         bits_in = load ? ins : from_right;
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         bits_ff <= '0;
      end else begin
         bits_ff <= bits_in;
      end
   end

   assign bits_q = bits_ff;

endmodule

// ===== rtl/mine_neighbour_count_3x3.sv =====
// ----------------------------------------------------------------------------
// mine_neighbour_count_3x3: streaming 3x3 mine counter
// Counts the mined cells in the 3x3 neighbourhood of every grid cell of a
// raster stream, using a chain of column cells as the two line stores.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  req     | in        | req_valid / req_ready | opcode, is_mine
//  rsp     | out       | rsp_valid / rsp_ready | mine_count, row_end, frame_end
//  csr     | in        | csr_valid / csr_ready | csr_index, csr_data
//
//  One item is taken per cycle while req_ready is high; its result, if any,
//  sits in the output register from the next cycle. The pace is set by the
//  shift of the line-store chain and the window, both updated at every item.
//  The result of a cell leaves with the item width+1 places later; the
//  first width+1 items of a frame give none.
//  Reset is synchronous and clears all state but the result payload at once.
//  A stalled result holds the output register; req_ready stays high as
//  long as that register is empty or being emptied in the same cycle.
//  Any register write restarts the frame.
//
module mine_neighbour_count_3x3
   import mnc_pkg::*;
#(
   parameter int MAX_WIDTH  = 64,
   parameter int MAX_HEIGHT = 1024
)
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_item_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_item_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // widths reachable through the register fields
   localparam int WLIM    = (MAX_WIDTH < GRID_WIDTH_TOP) ? MAX_WIDTH : GRID_WIDTH_TOP;
   localparam int HLIM    = (MAX_HEIGHT < GRID_HEIGHT_TOP) ? MAX_HEIGHT : GRID_HEIGHT_TOP;
   localparam int WEFF_W  = $clog2(WLIM + 1);
   localparam int COL_W   = (WLIM > 1) ? $clog2(WLIM) : 1;
   localparam int PRIME_W = $clog2(WLIM + 2);
   localparam int HEFF_W  = $clog2(HLIM + 1);
   localparam int ROW_W   = $clog2(HLIM + 2);
   localparam int RST_W   = (WLIM < GRID_WIDTH_RST) ? WLIM : GRID_WIDTH_RST;
   localparam int RST_H   = (HLIM < GRID_HEIGHT_RST) ? HLIM : GRID_HEIGHT_RST;

   function automatic logic [1:0] ones3(input logic [2:0] v);
      ones3 = {1'b0, v[0]} + {1'b0, v[1]} + {1'b0, v[2]};
   endfunction

   // effective geometry, clamped when written
   logic [WEFF_W-1:0]  w_eff_ff, w_eff_in;
   logic [COL_W-1:0]   w_last_ff, w_last_in;
   logic [HEFF_W-1:0]  h_eff_ff, h_eff_in;

   // frame position and window
   logic [COL_W-1:0]   col_ff, col_in;
   logic [ROW_W-1:0]   row_ff, row_in;
   logic [PRIME_W-1:0] prime_ff, prime_in;
   logic [8:0]         window_ff, window_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_item_type       rsp_data_ff, rsp_data_in;

   logic               req_take;
   logic               csr_take;
   logic               frame_last;
   logic               frame_clear;
   logic               has_result;
   logic               cell_bit;
   logic [2:0]         new_col;
   logic [COUNT_W-1:0] count;
   logic [ROW_W-1:0]   h_plus1;
   line_bits_type      line_ins;
   line_bits_type      line_q [WLIM];

   logic [GRID_WIDTH_W-1:0]  gw;
   logic [GRID_HEIGHT_W-1:0] gh;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign csr_ready = 1'b1;
   assign req_take  = req_valid && req_ready;
   assign csr_take  = csr_valid && csr_ready;

   assign h_plus1     = ROW_W'(h_eff_ff) + ROW_W'(1);
   assign frame_last  = (row_ff == h_plus1);
   assign frame_clear = (req_take && frame_last) || csr_take;
   assign has_result  = prime_ff > PRIME_W'(w_eff_ff);

   // cells past the bottom row and flush items enter as empty
   assign cell_bit = (req_data.opcode == OP_CELL) && (row_ff < ROW_W'(h_eff_ff))
                     && req_data.is_mine;
   assign new_col  = {cell_bit, line_q[0].middle, line_q[0].upper};

   // middle row moves up, the new cell becomes the middle row
   assign line_ins.upper  = line_q[0].middle;
   assign line_ins.middle = cell_bit;

   // line stores: chain of column cells, read at cell zero
   for (genvar k = 0; k < WLIM; k++) begin : g_line
      line_bits_type right;
      if (k == WLIM - 1) begin : g_end
         assign right = '0;
      end else begin : g_mid
         assign right = line_q[k+1];
      end
      mnc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .clear      (frame_clear),
         .shift      (req_take),
         .load       (w_last_ff == COL_W'(k)),
         .ins        (line_ins),
         .from_right (right),
         .bits_q     (line_q[k])
      );
   end

   // neighbourhood count; column zero closes the previous row's last cell
   always_comb begin
      count = '0;
      if (col_ff == '0) begin
         count = COUNT_W'(ones3(window_ff[8:6]));
         if (w_eff_ff > WEFF_W'(1)) begin
            count = count + COUNT_W'(ones3(window_ff[5:3]));
         end
      end else begin
         count = COUNT_W'(ones3(window_ff[8:6])) + COUNT_W'(ones3(new_col));
         if (col_ff > COL_W'(1)) begin
            count = count + COUNT_W'(ones3(window_ff[5:3]));
         end
      end
   end

   // configuration
   always_comb begin
      w_eff_in  = w_eff_ff;
      w_last_in = w_last_ff;
      h_eff_in  = h_eff_ff;
      gw        = csr_data[GRID_WIDTH_W-1:0];
      gh        = csr_data[GRID_HEIGHT_W-1:0];
      if (csr_take && csr_index == CSR_GRID_WIDTH) begin
         if (gw == '0) begin
            w_eff_in = WEFF_W'(1);
         end else if (gw > GRID_WIDTH_W'(WLIM)) begin
            w_eff_in = WEFF_W'(WLIM);
         end else begin
            w_eff_in = WEFF_W'(gw);
         end
         w_last_in = COL_W'(w_eff_in - WEFF_W'(1));
      end
      if (csr_take && csr_index == CSR_GRID_HEIGHT) begin
         if (gh == '0) begin
            h_eff_in = HEFF_W'(1);
         end else if (gh > GRID_HEIGHT_W'(HLIM)) begin
            h_eff_in = HEFF_W'(HLIM);
         end else begin
            h_eff_in = HEFF_W'(gh);
         end
      end
   end

   // position, window, priming and output register
   always_comb begin
      col_in       = col_ff;
      row_in       = row_ff;
      prime_in     = prime_ff;
      window_in    = window_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (req_take) begin
         window_in = {new_col, window_ff[8:3]};
         if (has_result) begin
            rsp_valid_in           = 1'b1;
            rsp_data_in.mine_count = count;
            rsp_data_in.row_end    = (col_ff == '0);
            rsp_data_in.frame_end  = (col_ff == '0) && frame_last;
         end else begin
            prime_in = prime_ff + PRIME_W'(1);
         end
         if (col_ff == w_last_ff) begin
            col_in = '0;
            row_in = row_ff + ROW_W'(1);
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
      // restart the frame after the last flush item or any register write
      if (frame_clear) begin
         col_in    = '0;
         row_in    = '0;
         prime_in  = '0;
         window_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         w_eff_ff     <= WEFF_W'(RST_W);
         w_last_ff    <= COL_W'(RST_W - 1);
         h_eff_ff     <= HEFF_W'(RST_H);
         col_ff       <= '0;
         row_ff       <= '0;
         prime_ff     <= '0;
         window_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         w_eff_ff     <= w_eff_in;
         w_last_ff    <= w_last_in;
         h_eff_ff     <= h_eff_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         prime_ff     <= prime_in;
         window_ff    <= window_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a result appears only after an item that produces one
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_take && has_result))
      else $error("result appeared without a producing item");

   // priming items leave the output register empty
   a_priming_quiet: assert property (@(posedge clock) disable iff (reset)
      (req_take && !has_result) |=> !rsp_valid_ff)
      else $error("result delivered during priming");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_data_ff.mine_count <= COUNT_W'(COUNT_MAX)))
      else $error("neighbourhood count above nine");

   a_frame_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.frame_end) |-> rsp_data_ff.row_end)
      else $error("frame end outside the last column");

   a_col_range: assert property (@(posedge clock) disable iff (reset)
      (col_ff <= w_last_ff) && (row_ff <= h_plus1))
      else $error("frame position beyond the grid");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the streaming 3x3 mine counter
// A short table of directed items (tiny grids, pad and flush corner cases),
// then random frames under several grid sizes and idling patterns. Every
// result is checked against a stated count or a cycle-free predictor of the counter.
// ----------------------------------------------------------------------------
module testbench;
   import mnc_pkg::*;

   localparam int MAX_W            = 64;
   localparam int MAX_H            = 1024;
   // the block has a single output register for the settle tail to cover
   localparam int SETTLE_CYCLES    = 4;
   localparam int WATCHDOG_LIMIT   = 4000;
   localparam int NOISE_PCT        = 8;
   localparam int PHASES_PER_MODE  = 3;
   localparam int LONG_HOLD_AT     = 24;
   localparam int LONG_HOLD_CYCLES = 80;

   // idling per mode: sender then receiver, percent of cycles
   localparam int SEND_IDLE [3] = '{23, 56, 0};
   localparam int TAKE_IDLE [3] = '{56, 23, 0};
   // the first phase of each mode forces a corner of the grid size
   localparam int EXTREME_W [3] = '{127, 64, 1};
   localparam int EXTREME_H [3] = '{3, 2047, 1024};

   // one row of the directed table: a register write or an item
   typedef struct packed {
      logic                  is_write;
      logic                  reg_index;
      logic [CSR_DATA_W-1:0] reg_value;
      req_item_type          item;
      logic                  typed;
      rsp_item_type          typed_rsp;
   } step_row_type;

   localparam req_item_type CELL_MINED = '{OP_CELL, 1'b1};
   localparam req_item_type CELL_CLEAR = '{OP_CELL, 1'b0};
   localparam req_item_type FLUSH      = '{OP_FLUSH, 1'b0};
   localparam req_item_type FLUSH_HIGH = '{OP_FLUSH, 1'b1};
   localparam rsp_item_type NO_RSP     = '0;
   // 1x1 grid: the count is the cell itself, on the last column and cell
   localparam rsp_item_type LONE_MINED = '{4'd1, 1'b1, 1'b1};
   localparam rsp_item_type LONE_CLEAR = '{4'd0, 1'b1, 1'b1};

   localparam int DIRECTED_ROWS = 29;
   localparam step_row_type DIRECTED [DIRECTED_ROWS] = '{
      // zero sizes act as a 1x1 grid
      '{1'b1, CSR_GRID_WIDTH,  11'd0, FLUSH, 1'b0, NO_RSP},
      '{1'b1, CSR_GRID_HEIGHT, 11'd0, FLUSH, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, FLUSH,      1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, FLUSH,      1'b1, LONE_MINED},
      // is_mine on a flush item is ignored
      '{1'b0, 1'b0, 11'd0, CELL_CLEAR, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, FLUSH,      1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, FLUSH_HIGH, 1'b1, LONE_CLEAR},
      // early flush stands in for an empty cell
      '{1'b0, 1'b0, 11'd0, FLUSH,      1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, FLUSH,      1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, FLUSH,      1'b1, LONE_CLEAR},
      // mined cells in the pad phase are taken as flush
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b1, LONE_MINED},
      // full 3x3 field: the centre reaches the top count
      '{1'b1, CSR_GRID_WIDTH,  11'd3, FLUSH, 1'b0, NO_RSP},
      '{1'b1, CSR_GRID_HEIGHT, 11'd3, FLUSH, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, CELL_MINED, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, FLUSH,      1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, FLUSH,      1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, FLUSH,      1'b0, NO_RSP},
      '{1'b0, 1'b0, 11'd0, FLUSH,      1'b0, NO_RSP}
   };

   logic                  clock;
   logic                  reset     = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_item_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_item_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = CSR_GRID_WIDTH;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   mine_neighbour_count_3x3 #(
      .MAX_WIDTH  (MAX_W),
      .MAX_HEIGHT (MAX_H)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // --------------------------------------------------------------------
   // Predictor: its own copy of the line stores, window and frame position
   // --------------------------------------------------------------------
   logic [GRID_WIDTH_W-1:0]  cfg_w;
   logic [GRID_HEIGHT_W-1:0] cfg_h;
   logic                     line_up  [MAX_W];
   logic                     line_mid [MAX_W];
   logic [8:0]               win;     // left column 2..0, centre 5..3, right 8..6
   int unsigned              pcol;
   int unsigned              prow;
   int unsigned              prime;

   rsp_item_type pending_counts [$];  // counts still owed by the block
   rsp_item_type oldest_count;
   int           counts_taken = 0;
   int           error_total  = 0;
   int           send_idle_pct = SEND_IDLE[0];
   int           take_idle_pct = TAKE_IDLE[0];
   int           mine_pct = 50;
   int           hold_left = 0;
   logic         long_hold_done = 1'b0;
   int           quiet_cycles = 0;

   function automatic int unsigned eff_w();
      if (cfg_w == 0) return 1;
      if (cfg_w > MAX_W) return MAX_W;
      return cfg_w;
   endfunction

   function automatic int unsigned eff_h();
      if (cfg_h == 0) return 1;
      if (cfg_h > MAX_H) return MAX_H;
      return cfg_h;
   endfunction

   function automatic void clear_frame();
      for (int c = 0; c < MAX_W; c++) begin
         line_up[c]  = 1'b0;
         line_mid[c] = 1'b0;
      end
      win   = '0;
      pcol  = 0;
      prow  = 0;
      prime = 0;
   endfunction

   // Advance the predictor by one item; returns 1 when the item yields a count.
   function automatic bit predict_count(input req_item_type it, output rsp_item_type res);
      int unsigned w, h, col, row, cnt;
      logic        cur;
      logic [2:0]  newcol;
      bit          got;
      w   = eff_w();
      h   = eff_h();
      col = pcol;
      row = prow;
      if (col >= MAX_W) col = 0;
      // pad rows and flush items feed an empty cell
      cur    = (it.opcode == OP_CELL && row < h) ? it.is_mine : 1'b0;
      newcol = {cur, line_mid[col], line_up[col]};
      res    = '0;
      if (col == 0) begin
         // wrap: the window still holds the last column of the row two up
         cnt = $countones(win[8:6]);
         if (w >= 2) cnt += $countones(win[5:3]);
         res.row_end   = 1'b1;
         res.frame_end = (row == h + 1);
         win = {newcol, win[8:3]};
      end else begin
         win = {newcol, win[8:3]};
         cnt = $countones(win[5:3]) + $countones(win[8:6]);
         if (col >= 2) cnt += $countones(win[2:0]);
      end
      res.mine_count = cnt[COUNT_W-1:0];
      line_up[col]   = line_mid[col];
      line_mid[col]  = cur;
      got = (prime >= w + 1);
      if (!got) prime++;
      if (row >= h + 1) begin
         clear_frame();
      end else begin
         col++;
         if (col >= w) begin
            col = 0;
            row++;
         end
         pcol = col;
         prow = row;
      end
      return got;
   endfunction

   // Mostly well-formed frames: cells inside the grid, flush in the pad.
   function automatic req_item_type pick_item();
      req_item_type it;
      if ($urandom_range(99) < NOISE_PCT) begin
         it.opcode  = 1'($urandom_range(1));
         it.is_mine = 1'($urandom_range(1));
      end else if (prow < eff_h()) begin
         it.opcode  = OP_CELL;
         it.is_mine = ($urandom_range(99) < mine_pct);
      end else begin
         it.opcode  = OP_FLUSH;
         it.is_mine = 1'($urandom_range(1));
      end
      return it;
   endfunction

   // --------------------------------------------------------------------
   // Sender side
   // --------------------------------------------------------------------
   // Offer one item, holding it until taken, then log its expected count.
   task automatic send_item(input req_item_type it, input logic typed,
                            input rsp_item_type typed_rsp);
      rsp_item_type res;
      bit           got;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      got = predict_count(it, res);
      // a typed row states its count outright; the predictor still advances
      if (typed) pending_counts = {pending_counts, typed_rsp};
      else if (got) pending_counts = {pending_counts, res};
   endtask

   // Drop valid and wait until every owed count is out, plus the pipe tail.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_counts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Register write; any write restarts the frame.
   task automatic write_reg(input logic idx, input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      if (idx == CSR_GRID_WIDTH) cfg_w = value[GRID_WIDTH_W-1:0];
      else cfg_h = value[GRID_HEIGHT_W-1:0];
      clear_frame();
   endtask

   // --------------------------------------------------------------------
   // Receiver side: random stalls, plus one long hold-off so that the
   // output register fills and the block stalls its input
   // --------------------------------------------------------------------
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!long_hold_done && counts_taken >= LONG_HOLD_AT) begin
         rsp_ready      <= 1'b0;
         hold_left      <= LONG_HOLD_CYCLES;
         long_hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= take_idle_pct);
      end
   end

   // Compare each accepted result with the oldest owed count.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         counts_taken <= counts_taken + 1;
         if (pending_counts.size() == 0) begin
            $display("%0t: unexpected result: count %0d row_end %0b frame_end %0b",
                     $time, rsp_data.mine_count, rsp_data.row_end, rsp_data.frame_end);
            error_total++;
         end else begin
            oldest_count = pending_counts.pop_front();
            if (rsp_data !== oldest_count) begin
               $display("%0t: mismatch: expected count %0d ends %0b%0b, got %0d ends %0b%0b",
                        $time, oldest_count.mine_count, oldest_count.row_end,
                        oldest_count.frame_end, rsp_data.mine_count,
                        rsp_data.row_end, rsp_data.frame_end);
               error_total++;
            end
         end
      end
   end

   // Watchdog: end the run if no channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("CHECK FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // --------------------------------------------------------------------
   // Main sequence
   // --------------------------------------------------------------------
   initial begin
      int          budget;
      int unsigned w_val;
      int unsigned h_val;
      cfg_w = GRID_WIDTH_RST;
      cfg_h = GRID_HEIGHT_RST;
      clear_frame();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table; writes only once the block has gone quiet
      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         if (DIRECTED[i].is_write) begin
            settle();
            write_reg(DIRECTED[i].reg_index, DIRECTED[i].reg_value);
         end else begin
            send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].typed_rsp);
         end
      end

      // random frames: three idling modes, several grid sizes in each
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = SEND_IDLE[mode];
         take_idle_pct = TAKE_IDLE[mode];
         for (int phase = 0; phase < PHASES_PER_MODE; phase++) begin
            if (phase == 0) begin
               w_val = EXTREME_W[mode];
               h_val = EXTREME_H[mode];
            end else begin
               // mostly small grids, now and then an odd or large one
               case ($urandom_range(9))
                  0:       w_val = 0;
                  1:       w_val = $urandom_range(127, 65);
                  2:       w_val = $urandom_range(64, 9);
                  default: w_val = $urandom_range(8, 1);
               endcase
               case ($urandom_range(9))
                  0:       h_val = 0;
                  1:       h_val = $urandom_range(2047, 1024);
                  2:       h_val = $urandom_range(40, 6);
                  default: h_val = $urandom_range(5, 1);
               endcase
            end
            mine_pct = $urandom_range(100);
            // the top bits of a width write are dropped by the block
            settle();
            write_reg(CSR_GRID_WIDTH, {4'($urandom_range(15)), 7'(w_val)});
            settle();
            write_reg(CSR_GRID_HEIGHT, 11'(h_val));
            budget = $urandom_range(45, 25);
            // wide rows need room for priming before counts come out
            if (eff_w() > 16) budget += eff_w() + 1;
            for (int n = 0; n < budget; n++) send_item(pick_item(), 1'b0, NO_RSP);
         end
      end

      settle();
      if (error_total == 0 && pending_counts.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/mnc_pkg.sv
rtl/mnc_cell.sv
rtl/mine_neighbour_count_3x3.sv
bench/testbench.sv
